FILE: src/sfr_pkg.sv
// Shared types and constants of the stream find-and-replace block.
package sfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 4;
  localparam int MAX_OUT    = 8;
  localparam int OUT_IDX_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = 2;
  localparam int Q_CNT_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES,
    REG_PATTERN_LENGTH,
    REG_SUBSTITUTE_BYTES,
    REG_SUBSTITUTE_LENGTH
  } cfg_reg_t;

  typedef struct packed {
    logic                  en;
    cfg_reg_t              index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // One burst of results: n bytes in order, marker only when n is zero
  typedef struct packed {
    logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
    logic [LEN_W-1:0]               n;
    logic                           last;
  } cmd_t;

endpackage

FILE: src/sfr_front.sv
// Front end: configuration registers, pending window and match classification.
module sfr_front import sfr_pkg::*; #(
  parameter int MAX_PATTERN    = 8,
  parameter int MAX_SUBSTITUTE = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_wr_t           cfg,
  input  logic              in_take,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_last,
  output logic              cmd_valid,
  output cmd_t              cmd
);

  localparam int WIN  = (MAX_PATTERN < MAX_OUT) ? MAX_PATTERN : MAX_OUT;
  localparam int SCAP = (MAX_SUBSTITUTE < MAX_OUT) ? MAX_SUBSTITUTE : MAX_OUT;
  localparam int CW   = $clog2(WIN + 1);

  logic [CFG_DATA_W-1:0] pat_bytes;
  logic [LEN_W-1:0]      pat_len;
  logic [CFG_DATA_W-1:0] sub_bytes;
  logic [LEN_W-1:0]      sub_len;

  logic [BYTE_W-1:0] win    [WIN];
  logic [BYTE_W-1:0] newwin [WIN];
  logic [CW-1:0]     count;

  logic [LEN_W-1:0] plen_eff;
  logic [LEN_W-1:0] slen_eff;
  logic [CW-1:0]    plen_c;
  logic [CW-1:0]    cnt0;
  logic [CW-1:0]    cnt1;
  logic             is_full;
  logic             match;
  logic             hit;

  always_comb begin
    if (pat_len == '0) begin
      plen_eff = LEN_W'(1);
    end else if (pat_len > LEN_W'(WIN)) begin
      plen_eff = LEN_W'(WIN);
    end else begin
      plen_eff = pat_len;
    end
    slen_eff = (sub_len > LEN_W'(SCAP)) ? LEN_W'(SCAP) : sub_len;
    plen_c   = CW'(plen_eff);

    cnt0 = (count >= plen_c) ? '0 : count;
    cnt1 = cnt0 + CW'(1);
    for (int i = 0; i < WIN; i++) begin
      newwin[i] = (CW'(i) == cnt0) ? in_byte : win[i];
    end
    is_full = (cnt1 == plen_c);

    match = 1'b1;
    for (int i = 0; i < WIN; i++) begin
      if (CW'(i) < plen_c && newwin[i] != pat_bytes[BYTE_W*i +: BYTE_W]) begin
        match = 1'b0;
      end
    end
    hit = is_full && match;

    for (int k = 0; k < MAX_OUT; k++) begin
      if (hit) begin
        cmd.bytes[k] = sub_bytes[BYTE_W*k +: BYTE_W];
      end else if (k < WIN) begin
        cmd.bytes[k] = newwin[k];
      end else begin
        cmd.bytes[k] = '0;
      end
    end

    // hit: substitute; last: whole window; full miss: oldest byte only
    if (hit) begin
      cmd.n = slen_eff;
    end else if (in_last) begin
      cmd.n = LEN_W'(cnt1);
    end else if (is_full) begin
      cmd.n = LEN_W'(1);
    end else begin
      cmd.n = '0;
    end
    cmd.last  = in_last;
    cmd_valid = in_take && (cmd.n != '0 || in_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_bytes <= '0;
      pat_len   <= LEN_W'(1);
      sub_bytes <= '0;
      sub_len   <= '0;
      count     <= '0;
    end else begin
      if (cfg.en) begin
        unique case (cfg.index)
          REG_PATTERN_BYTES:     pat_bytes <= cfg.data;
          REG_PATTERN_LENGTH: begin
            pat_len <= cfg.data[LEN_W-1:0];
            count   <= '0;
          end
          REG_SUBSTITUTE_BYTES:  sub_bytes <= cfg.data;
          REG_SUBSTITUTE_LENGTH: sub_len   <= cfg.data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_take) begin
        if (in_last || hit) begin
          count <= '0;
        end else if (is_full) begin
          count <= plen_c - CW'(1);
        end else begin
          count <= cnt1;
        end
      end
    end
  end

  // Window contents: shift down when the window is full, else take the new byte
  always_ff @(posedge clk) begin
    if (in_take) begin
      if (is_full) begin
        for (int i = 0; i < WIN - 1; i++) begin
          win[i] <= newwin[i + 1];
        end
      end else begin
        for (int i = 0; i < WIN; i++) begin
          win[i] <= newwin[i];
        end
      end
    end
  end

endmodule

FILE: src/sfr_cmdq.sv
// Short command queue between the front end and the output sequencer.
module sfr_cmdq import sfr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty,
  output logic full
);

  cmd_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_wr;
  logic               do_rd;

  assign empty   = (count == '0);
  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      priority if (do_wr && !do_rd) begin
        count <= count + Q_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: src/sfr_back.sv
// Back end: expands each queued command into results, one per cycle unless the receiver stalls.
module sfr_back import sfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              head,
  input  logic              head_avail,
  output logic              head_pop,
  input  logic              pop,
  output logic              empty,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_valid,
  output logic              out_last
);

  logic [OUT_IDX_W-1:0] idx;
  logic                 out_load;
  logic                 n_zero;
  logic                 at_end;

  assign out_load = empty || pop;
  assign n_zero   = (head.n == '0);
  assign at_end   = n_zero || (LEN_W'(idx) == head.n - LEN_W'(1));
  assign head_pop = out_load && head_avail && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      empty <= 1'b1;
      idx   <= '0;
    end else if (out_load) begin
      if (head_avail) begin
        empty <= 1'b0;
        idx   <= at_end ? '0 : idx + OUT_IDX_W'(1);
      end else begin
        empty <= 1'b1;
      end
    end
  end

  // Output register; a marker carries a zero byte
  always_ff @(posedge clk) begin
    if (out_load && head_avail) begin
      out_byte  <= n_zero ? '0 : head.bytes[idx];
      out_valid <= !n_zero;
      out_last  <= head.last && at_end;
    end
  end

endmodule

FILE: src/stream_find_replace.sv
// Path: an accepted byte's command is written into the queue, and the back end
// then loads its first result into the output register.
// Throughput: one input byte per cycle while full is low; results leave one
// per cycle while popped, so a substitute or flush of n bytes holds the output
// for n results; a 4-entry command queue absorbs bursts before full is raised.
// Reset: synchronous; clears the window, queue and output, and loads register
// defaults (pattern length 1, all else 0).
module stream_find_replace import sfr_pkg::*; #(
  parameter int MAX_PATTERN    = 8,
  parameter int MAX_SUBSTITUTE = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [BYTE_W-1:0]     in_byte,
  input  logic                  in_last,
  output logic                  empty,
  input  logic                  pop,
  output logic [BYTE_W-1:0]     out_byte,
  output logic                  out_valid,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_wr_t cfg;
  cmd_t    cmd;
  cmd_t    head;
  logic    cmd_valid;
  logic    in_take;
  logic    q_empty;
  logic    q_full;
  logic    q_pop;

  assign cfg_ready  = 1'b1;
  assign cfg.en     = cfg_valid;
  assign cfg.index  = cfg_reg_t'(cfg_index);
  assign cfg.data   = cfg_data;
  assign full       = q_full;
  assign in_take    = push && !q_full;

  sfr_front #(
    .MAX_PATTERN    (MAX_PATTERN),
    .MAX_SUBSTITUTE (MAX_SUBSTITUTE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_take   (in_take),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  sfr_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_valid),
    .wr_data (cmd),
    .rd_en   (q_pop),
    .rd_data (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  sfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_avail (!q_empty),
    .head_pop   (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .out_valid  (out_valid),
    .out_last   (out_last)
  );

  a_no_enq_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !cmd_valid)
    else $error("command enqueued into a full queue");

  a_empty_cmd_is_last: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd.n == '0) |-> cmd.last)
    else $error("empty command without end-of-text mark");

  a_cmd_len_bound: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> (cmd.n <= LEN_W'(MAX_OUT)))
    else $error("command longer than the result limit");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && q_empty))
    else $error("output or queue not empty after reset");

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the stream find-and-replace block.
`timescale 1ns / 100ps

module tb_top;
  import sfr_pkg::*;

  localparam int SETTLE  = 8;   // cycles let pass before a register write
  localparam int TAIL    = 16;  // cycles watched after the last expected result
  localparam int QUOTA   = 22;  // random bytes per phase, at least
  localparam int LONG_HOLD = 120;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              valid;
    logic              last;
  } rw_res_t;

  typedef struct packed {
    logic                  is_cfg;
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] val;
    logic [BYTE_W-1:0]     b;
    logic                  l;
    logic                  typed;
    rw_res_t               want;
  } dir_row_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  push      = 1'b0;
  logic [BYTE_W-1:0]     in_byte   = '0;
  logic                  in_last   = 1'b0;
  logic                  pop       = 1'b0;
  logic                  cfg_valid = 1'b0;
  cfg_reg_t              cfg_index = REG_PATTERN_BYTES;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  full;
  logic                  empty;
  logic [BYTE_W-1:0]     out_byte;
  logic                  out_valid;
  logic                  out_last;
  logic                  cfg_ready;

  stream_find_replace u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: registers and pending window
  logic [CFG_DATA_W-1:0] pat_bytes_r = '0;
  logic [LEN_W-1:0]      pat_len_r   = 4'd1;
  logic [CFG_DATA_W-1:0] sub_bytes_r = '0;
  logic [LEN_W-1:0]      sub_len_r   = '0;
  logic [BYTE_W-1:0]     win [8];
  int                    win_cnt     = 0;

  rw_res_t step_out [$];
  rw_res_t due_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asks      = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int err_cnt        = 0;
  int n_bytes        = 0;
  int n_texts        = 0;
  int n_results      = 0;
  int n_cfg          = 0;
  int full_cycles    = 0;
  rw_res_t seen, due;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int eff_pat_len();
    if (pat_len_r == 0) return 1;
    if (pat_len_r > 8) return 8;
    return int'(pat_len_r);
  endfunction

  // Work out the results that one byte causes and advance the window
  task automatic rewrite_step(input logic [BYTE_W-1:0] b, input logic l);
    int plen;
    int slen;
    bit hit;
    rw_res_t r;
    plen = eff_pat_len();
    slen = (sub_len_r > 8) ? 8 : int'(sub_len_r);
    step_out.delete();
    if (win_cnt >= plen) win_cnt = 0;
    win[win_cnt % 8] = b;
    win_cnt++;
    if (win_cnt == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++)
        if (win[i] != pat_bytes_r[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        for (int i = 0; i < slen; i++) step_out.push_back({sub_bytes_r[8*i +: 8], 1'b1, 1'b0});
        win_cnt = 0;
      end else begin
        step_out.push_back({win[0], 1'b1, 1'b0});
        for (int i = 1; i < plen; i++) win[i-1] = win[i];
        win_cnt--;
      end
    end
    if (l) begin
      for (int i = 0; i < win_cnt; i++) step_out.push_back({win[i], 1'b1, 1'b0});
      win_cnt = 0;
      // nothing to send: marker only
      if (step_out.size() == 0) step_out.push_back({8'h00, 1'b0, 1'b0});
      r = step_out.pop_back();
      r.last = 1'b1;
      step_out.push_back(r);
    end
  endtask

  // Offer one byte; leaves push high so a following byte can go back to back
  task automatic offer(input logic [BYTE_W-1:0] b, input logic l, input logic typed,
                       input rw_res_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    in_last <= l;
    @(posedge clk);
    while (full) begin
      full_cycles++;
      @(posedge clk);
    end
    rewrite_step(b, l);
    if (typed) due_q.push_back(want);
    else foreach (step_out[i]) due_q.push_back(step_out[i]);
    n_bytes++;
    if (l) n_texts++;
    @(negedge clk);
  endtask

  // Write a register once the block has drained
  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    push <= 1'b0;
    while (due_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PATTERN_BYTES:     pat_bytes_r = val;
      REG_PATTERN_LENGTH: begin
        pat_len_r = val[LEN_W-1:0];
        win_cnt   = 0;
      end
      REG_SUBSTITUTE_BYTES:  sub_bytes_r = val;
      REG_SUBSTITUTE_LENGTH: sub_len_r   = val[LEN_W-1:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic dir_row_t cfg_row(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    return '{1'b1, idx, val, 8'h00, 1'b0, 1'b0, '0};
  endfunction

  function automatic dir_row_t byte_row(input logic [BYTE_W-1:0] b, input logic l);
    return '{1'b0, REG_PATTERN_BYTES, '0, b, l, 1'b0, '0};
  endfunction

  function automatic dir_row_t byte_row_exp(input logic [BYTE_W-1:0] b, input logic l,
                                            input logic [BYTE_W-1:0] eb, input logic ev,
                                            input logic el);
    return '{1'b0, REG_PATTERN_BYTES, '0, b, l, 1'b1, {eb, ev, el}};
  endfunction

  task automatic report_mismatch(input string what, input rw_res_t got, input rw_res_t want);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch (%s) at %0t: got byte %02h valid %0b last %0b, expected byte %02h valid %0b last %0b",
               what, $time, got.data, got.valid, got.last, want.data, want.valid, want.last);
  endtask

  // Receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= LONG_HOLD;
      pop       <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      seen = {out_byte, out_valid, out_last};
      n_results++;
      if (due_q.size() == 0) begin
        report_mismatch("no result due", seen, '0);
      end else begin
        due = due_q.pop_front();
        if (seen.data !== due.data || seen.valid !== due.valid || seen.last !== due.last)
          report_mismatch("wrong field", seen, due);
      end
    end
  end

  initial begin
    dir_row_t dir_tab [];
    logic [BYTE_W-1:0] text_q [$];
    int sent;
    int plen;
    int k;
    int n;
    dir_tab = '{
      // after reset: pattern is one zero byte, substitute empty
      byte_row_exp(8'h41, 1'b0, 8'h41, 1'b1, 1'b0),
      byte_row(8'h00, 1'b0),
      byte_row_exp(8'h00, 1'b1, 8'h00, 1'b0, 1'b1),
      byte_row_exp(8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1),
      cfg_row(REG_PATTERN_BYTES, 64'h6261),
      cfg_row(REG_PATTERN_LENGTH, 64'd2),
      cfg_row(REG_SUBSTITUTE_BYTES, 64'h5A5958),
      cfg_row(REG_SUBSTITUTE_LENGTH, 64'd3),
      byte_row(8'h78, 1'b0),
      byte_row(8'h61, 1'b0),
      byte_row(8'h62, 1'b0),
      byte_row(8'h61, 1'b0),
      byte_row(8'h62, 1'b1),
      byte_row(8'h61, 1'b0),
      byte_row(8'h61, 1'b0),
      byte_row(8'h62, 1'b0),
      byte_row(8'h61, 1'b1),
      // widest pattern and substitute
      cfg_row(REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF),
      cfg_row(REG_PATTERN_LENGTH, 64'd8),
      cfg_row(REG_SUBSTITUTE_BYTES, 64'h0123_4567_89AB_CDEF),
      cfg_row(REG_SUBSTITUTE_LENGTH, 64'd8),
      byte_row(8'hFF, 1'b0),
      byte_row(8'hFF, 1'b0),
      byte_row(8'hFF, 1'b0),
      byte_row(8'hFF, 1'b0),
      byte_row(8'hFF, 1'b0),
      byte_row(8'hFF, 1'b0),
      byte_row(8'hFF, 1'b0),
      byte_row(8'hFF, 1'b1),
      // zero pattern length acts as one, oversized substitute length saturates
      cfg_row(REG_PATTERN_LENGTH, 64'd0),
      cfg_row(REG_SUBSTITUTE_LENGTH, 64'd15),
      byte_row(8'hFF, 1'b1),
      // oversized pattern length, then a rewrite mid-text drops the pending byte
      cfg_row(REG_PATTERN_LENGTH, 64'd15),
      byte_row(8'h11, 1'b0),
      cfg_row(REG_PATTERN_LENGTH, 64'd1),
      byte_row_exp(8'h22, 1'b1, 8'h22, 1'b1, 1'b1)
    };

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) cfg_write(dir_tab[i].idx, dir_tab[i].val);
      else offer(dir_tab[i].b, dir_tab[i].l, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      cfg_write(REG_PATTERN_BYTES, {$urandom, $urandom});
      case (ph)
        0: cfg_write(REG_PATTERN_LENGTH, 64'd1);
        1: cfg_write(REG_PATTERN_LENGTH, 64'($urandom_range(2, 4)));
        2: cfg_write(REG_PATTERN_LENGTH, 64'd8);
        default: cfg_write(REG_PATTERN_LENGTH, 64'($urandom_range(0, 15)));
      endcase
      cfg_write(REG_SUBSTITUTE_BYTES, {$urandom, $urandom});
      case (ph)
        0: cfg_write(REG_SUBSTITUTE_LENGTH, 64'($urandom_range(0, 8)));
        1: cfg_write(REG_SUBSTITUTE_LENGTH, 64'd0);
        2: cfg_write(REG_SUBSTITUTE_LENGTH, 64'd8);
        default: cfg_write(REG_SUBSTITUTE_LENGTH, 64'($urandom_range(0, 15)));
      endcase
      // hold the receiver off while the sender keeps pushing
      if (ph == 0) hold_asks++;

      sent = 0;
      while (sent < QUOTA) begin
        plen = eff_pat_len();
        text_q.delete();
        repeat ($urandom_range(1, 5)) begin
          k = $urandom_range(99);
          if (k < 45) begin
            for (int i = 0; i < plen; i++) text_q.push_back(pat_bytes_r[8*i +: 8]);
          end else if (k < 65) begin
            n = $urandom_range(1, plen);
            for (int i = 0; i < n; i++) text_q.push_back(pat_bytes_r[8*i +: 8]);
          end else begin
            text_q.push_back(8'($urandom_range(255)));
          end
        end
        foreach (text_q[i]) offer(text_q[i], i == text_q.size() - 1, 1'b0, '0);
        sent += text_q.size();
      end
    end

    push <= 1'b0;
    while (due_q.size() != 0) @(negedge clk);
    repeat (TAIL) @(negedge clk);

    $display("covered %0d bytes in %0d texts over %0d register writes, %0d results checked",
             n_bytes, n_texts, n_cfg, n_results);
    $display("input held off by full for %0d cycles, %0d mismatches", full_cycles, err_cnt);
    if (err_cnt == 0 && due_q.size() == 0) begin
      $display("[stream_find_replace] OK");
    end else begin
      $display("[stream_find_replace] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", due_q.size());
    $display("[stream_find_replace] ERROR");
    $finish;
  end

endmodule
